>>> hw/rtl/odo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometer package
// Shared constants, codes and controller/datapath interface types for the
// dual quadrature odometer.
// ----------------------------------------------------------------------------
package odo_pkg;

  // Default width of the wrapping step counters
  localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIAMETER = 2'd0;
  localparam logic [1:0] CFG_STEPS    = 2'd1;
  localparam logic [1:0] CFG_GEAR     = 2'd2;

  // Configuration reset values
  localparam logic [7:0] DIAMETER_RST = 8'd39;
  localparam logic [7:0] STEPS_RST    = 8'd12;
  localparam logic [7:0] GEAR_RST     = 8'd75;

  // Request opcodes
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Circumference = diameter * 3141 / 1000, done as a reciprocal multiply.
  // The rounding error over all 8-bit diameters stays below 1/1000.
  localparam longint unsigned PI_NUM     = 64'd3141;
  localparam longint unsigned PI_DEN     = 64'd1000;
  localparam int unsigned     CIRC_SHIFT = 20;
  localparam longint unsigned CIRC_MUL_L =
    (PI_NUM * (64'd1 << CIRC_SHIFT) + PI_DEN - 64'd1) / PI_DEN;
  localparam int unsigned     CIRC_MUL_W = 22;
  localparam logic [CIRC_MUL_W-1:0] CIRC_MUL = CIRC_MUL_W'(CIRC_MUL_L);
  localparam int unsigned     DIAM_W      = 8;
  localparam int unsigned     CIRC_PROD_W = DIAM_W + CIRC_MUL_W;
  localparam int unsigned     CIRC_W      = CIRC_PROD_W - CIRC_SHIFT;

  // Divisor (steps * gear) and quotient widths
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned QUO_W   = 31;
  localparam int unsigned DCNT_W  = $clog2(QUO_W);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(QUO_W - 1);

  // Saturation limits of the distance
  localparam logic [31:0] DIST_SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] DIST_SAT_NEG = 32'h8000_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic take;     // request accepted: update counts and levels
    logic sum_en;   // halved sum, circumference, divisor
    logic mag_en;   // sign and magnitude
    logic mul_en;   // magnitude times circumference
    logic chk_en;   // overflow check, divider set-up
    logic div_en;   // one quotient bit
    logic load_en;  // load result register
  } odo_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done; // last quotient bit in this cycle
  } odo_sts_t;

endpackage

>>> hw/rtl/odo_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometer controller
// Sequences one request through the datapath and owns the stream handshakes.
// ----------------------------------------------------------------------------
module odo_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  odo_pkg::odo_sts_t sts_i,
  output odo_pkg::odo_cmd_t cmd_o
);
  import odo_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MAG,
    S_MUL,
    S_CHK,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   out_valid_q;
  logic   out_free;

  assign in_ready_o  = ready_q;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Commands decoded from state
  always_comb begin
    cmd_o         = '0;
    cmd_o.take    = in_valid_i && ready_q;
    cmd_o.sum_en  = (state_q == S_SUM);
    cmd_o.mag_en  = (state_q == S_MAG);
    cmd_o.mul_en  = (state_q == S_MUL);
    cmd_o.chk_en  = (state_q == S_CHK);
    cmd_o.div_en  = (state_q == S_DIV);
    cmd_o.load_en = (state_q == S_OUT) && out_free;
  end

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // Result valid: set on load, cleared once taken
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= S_SUM;
            ready_q <= 1'b0;
          end
        end
        S_SUM: state_q <= S_MAG;
        S_MAG: state_q <= S_MUL;
        S_MUL: state_q <= S_CHK;
        S_CHK: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  // Checks
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("ready outside idle");

  a_sum_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUM |-> $past(in_valid_i && in_ready_o))
    else $error("sum step without accepted request");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_en |=> out_valid_o)
    else $error("result loaded but not presented");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_done) |=> state_q == S_OUT)
    else $error("divider finished without result step");

endmodule

>>> hw/rtl/odo_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometer datapath
// Quadrature counters, configuration registers, distance arithmetic with a
// bit-serial divider and the result register.
// ----------------------------------------------------------------------------
module odo_dp #(
  parameter int unsigned COUNT_WIDTH = odo_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  odo_pkg::odo_cmd_t cmd_i,
  output odo_pkg::odo_sts_t sts_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              opcode_i,
  input  logic              motor_select_i,
  input  logic [1:0]        xor_level_i,   // [0] left, [1] right
  input  logic [1:0]        b_level_i,     // [0] left, [1] right
  output logic [31:0]       left_count_o,
  output logic [31:0]       right_count_o,
  output logic [31:0]       distance_mm_o
);
  import odo_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + CIRC_W;
  localparam int unsigned HI_MIN = QUO_W + STEPS_W;
  localparam int unsigned PE     = (PROD_W > HI_MIN) ? PROD_W : HI_MIN;
  localparam int unsigned HI_W   = PE - QUO_W;

  // Configuration
  logic [7:0] diam_q, spr_q, gear_q;

  // Encoder state
  logic [COUNT_WIDTH-1:0] cnt_q [2];
  logic [1:0]             prev_a_q, prev_b_q;

  // Arithmetic pipeline
  logic [COUNT_WIDTH-1:0] avg_q, mag_q;
  logic                   neg_q;
  logic [CIRC_W-1:0]      circ_q;
  logic [STEPS_W-1:0]     steps_q;
  logic [PE-1:0]          prod_q;
  logic                   big_q, zero_q;
  logic [STEPS_W-1:0]     rem_q;
  logic [QUO_W-1:0]       quo_q;
  logic [DCNT_W-1:0]      div_cnt_q;
  logic [31:0]            left_q, right_q, dist_q;

  logic [1:0]             a_lvl;
  logic                   inc, dec;
  logic [COUNT_WIDTH-1:0] cnt_upd;
  logic [COUNT_WIDTH:0]   sum;
  logic [CIRC_PROD_W-1:0] circ_prod;
  logic [HI_W-1:0]        hi;
  logic [STEPS_W:0]       rem_sh;
  logic                   ge;
  logic [STEPS_W-1:0]     rem_nxt;
  logic [31:0]            quo_ext, dist_d;

  // Quadrature decode of the selected encoder
  assign a_lvl   = xor_level_i ^ b_level_i;
  assign inc     = a_lvl[motor_select_i] ^ prev_b_q[motor_select_i];
  assign dec     = b_level_i[motor_select_i] ^ prev_a_q[motor_select_i];
  assign cnt_upd = cnt_q[motor_select_i] + COUNT_WIDTH'(inc) - COUNT_WIDTH'(dec);

  // Floor of the halved sum of both signed counts
  assign sum = {cnt_q[0][COUNT_WIDTH-1], cnt_q[0]} + {cnt_q[1][COUNT_WIDTH-1], cnt_q[1]};

  // Circumference by reciprocal multiply
  assign circ_prod = CIRC_PROD_W'(diam_q) * CIRC_PROD_W'(CIRC_MUL);

  // Quotient at or above 2^31 saturates either way
  assign hi = prod_q[PE-1:QUO_W];

  // Restoring divide, one bit a cycle
  assign rem_sh  = {rem_q, prod_q[QUO_W-1]};
  assign ge      = rem_sh >= {1'b0, steps_q};
  assign rem_nxt = ge ? STEPS_W'(rem_sh - {1'b0, steps_q}) : rem_sh[STEPS_W-1:0];

  // Signed, saturated distance
  assign quo_ext = {1'b0, quo_q};
  always_comb begin
    priority if (zero_q) begin
      dist_d = '0;
    end else if (big_q) begin
      dist_d = neg_q ? DIST_SAT_NEG : DIST_SAT_POS;
    end else begin
      dist_d = neg_q ? (~quo_ext + 32'd1) : quo_ext;
    end
  end

  assign sts_o.div_done = (div_cnt_q == '0);

  // Control state: configuration, counts, levels, divide counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q    <= DIAMETER_RST;
      spr_q     <= STEPS_RST;
      gear_q    <= GEAR_RST;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      prev_a_q  <= '0;
      prev_b_q  <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_DIAMETER) diam_q <= cfg_data_i;
        if (cfg_index_i == CFG_STEPS)    spr_q  <= cfg_data_i;
        if (cfg_index_i == CFG_GEAR)     gear_q <= cfg_data_i;
      end
      if (cmd_i.take) begin
        if (opcode_i == OP_CLEAR) begin
          cnt_q[0] <= '0;
          cnt_q[1] <= '0;
          prev_a_q <= a_lvl;
          prev_b_q <= b_level_i;
        end else begin
          cnt_q[motor_select_i]    <= cnt_upd;
          prev_a_q[motor_select_i] <= a_lvl[motor_select_i];
          prev_b_q[motor_select_i] <= b_level_i[motor_select_i];
        end
      end
      if (cmd_i.chk_en) begin
        div_cnt_q <= DIV_LAST;
      end else if (cmd_i.div_en) begin
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
      end
    end
  end

  // Arithmetic payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      avg_q   <= sum[COUNT_WIDTH:1];
      circ_q  <= circ_prod[CIRC_PROD_W-1:CIRC_SHIFT];
      steps_q <= {8'd0, spr_q} * {8'd0, gear_q};
    end
    if (cmd_i.mag_en) begin
      neg_q <= avg_q[COUNT_WIDTH-1];
      mag_q <= avg_q[COUNT_WIDTH-1] ? (~avg_q + COUNT_WIDTH'(1)) : avg_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= PE'(mag_q) * PE'(circ_q);
      zero_q <= (steps_q == '0) || (circ_q == '0);
    end else if (cmd_i.div_en) begin
      prod_q <= {prod_q[PE-2:0], 1'b0};
    end
    if (cmd_i.chk_en) begin
      big_q <= hi >= HI_W'(steps_q);
      rem_q <= hi[STEPS_W-1:0];
    end else if (cmd_i.div_en) begin
      rem_q <= rem_nxt;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
    if (cmd_i.load_en) begin
      left_q  <= 32'(cnt_q[0]);
      right_q <= 32'(cnt_q[1]);
      dist_q  <= dist_d;
    end
  end

  assign left_count_o  = left_q;
  assign right_count_o = right_q;
  assign distance_mm_o = dist_q;

endmodule

>>> hw/rtl/dual_quadrature_odometer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual quadrature odometer
// Decodes two XOR/B encoder pin pairs into signed step counts and reports
// the travelled wheel distance in millimetres.
//
// Usage:
// - Slave stream takes one request per encoder event or clear; tuser holds
//   the opcode and motor select, tdata the four pin levels.
// - Master stream returns exactly one result per request: both counts and
//   the saturated distance, packed into 96 bits of tdata.
// - Configuration channel writes diameter, steps per revolution and gear
//   ratio; it is always ready and should only be used while no request is
//   in flight.
// - An accepted request passes through the sum, magnitude, multiply and
//   check steps and the bit-serial divider before its result is valid; no
//   new request is taken until the previous result is loaded.
// - A finished result waits in the output register while the next request
//   is accepted; the block holds the following result until the receiver
//   takes the earlier one.
// - Reset clears both counts and stored levels and loads the default
//   configuration (39 mm, 12 steps, ratio 75).
// ----------------------------------------------------------------------------
module dual_quadrature_odometer #(
  parameter int unsigned COUNT_WIDTH = odo_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // left_xor_level, left_b_level,
                                     // right_xor_level, right_b_level, zero pad
  input  logic [1:0]  s_axis_tuser,  // opcode, motor_select
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // left_count, right_count, distance_mm
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import odo_pkg::*;

  odo_cmd_t    cmd;
  odo_sts_t    sts;
  logic [31:0] left_count, right_count, distance_mm;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  odo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Counters and arithmetic
  odo_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (s_axis_tuser[0]),
    .motor_select_i (s_axis_tuser[1]),
    .xor_level_i    ({s_axis_tdata[2], s_axis_tdata[0]}),
    .b_level_i      ({s_axis_tdata[3], s_axis_tdata[1]}),
    .left_count_o   (left_count),
    .right_count_o  (right_count),
    .distance_mm_o  (distance_mm)
  );

  assign m_axis_tdata = {distance_mm, right_count, left_count};

endmodule

>>> verif/tb_dual_quadrature_odometer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual quadrature odometer testbench
// Drives encoder event and clear requests over the request stream and checks
// every result against a cycle-free model of the counters and the distance
// arithmetic. A short table of hand-checked requests comes first. Random
// quadrature walks with some noise and clears follow, over several wheel,
// encoder and gear settings, zero divisors among them. Both streams idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_dual_quadrature_odometer;
  import odo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 600;
  localparam int unsigned HOLD_AT = 250;
  localparam logic [31:0] MINUS_ONE = 32'hFFFF_FFFF;

  // One result, laid out as on the result stream (left count lowest)
  typedef struct packed {
    logic [31:0] distance;
    logic [31:0] right;
    logic [31:0] left;
  } odo_result_t;

  // One row of the directed table
  typedef struct packed {
    logic        op;
    logic        sel;
    logic [3:0]  pins;   // right_b, right_xor, left_b, left_xor
    logic        typed;
    odo_result_t want;
  } odo_row_t;

  localparam int unsigned N_ROWS = 14;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  // Model state
  logic [7:0]  wheel_mm = DIAMETER_RST;
  logic [7:0]  steps_rev = STEPS_RST;
  logic [7:0]  gear_red = GEAR_RST;
  logic [31:0] enc_count [2] = '{32'd0, 32'd0};
  logic [1:0]  last_a = '0;
  logic [1:0]  last_b = '0;

  // Pin levels currently driven, per encoder
  logic [1:0]  pin_a = '0;
  logic [1:0]  pin_b = '0;

  odo_result_t pending_results [$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;

  // Hand-checked requests under the reset configuration
  odo_row_t directed_rows [N_ROWS] = '{
    '{OP_CLEAR, 1'b0, 4'b0000, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{OP_EVENT, 1'b0, 4'b0001, 1'b1, '{32'd0, 32'd0, 32'd1}},
    '{OP_EVENT, 1'b0, 4'b0010, 1'b1, '{32'd0, 32'd0, 32'd2}},
    '{OP_EVENT, 1'b1, 4'b1110, 1'b1, '{32'd0, MINUS_ONE, 32'd2}},
    '{OP_EVENT, 1'b1, 4'b0110, 1'b1, '{32'd0, MINUS_ONE, 32'd2}},  // both pins jump
    '{OP_EVENT, 1'b0, 4'b0110, 1'b1, '{32'd0, MINUS_ONE, 32'd2}},  // no change
    '{OP_EVENT, 1'b0, 4'b0100, 1'b1, '{32'd0, MINUS_ONE, 32'd2}},  // both pins fall
    '{OP_CLEAR, 1'b1, 4'b1111, 1'b1, '{32'd0, 32'd0, 32'd0}},      // select ignored
    '{OP_EVENT, 1'b1, 4'b0011, 1'b1, '{32'd0, 32'd1, 32'd0}},
    '{OP_EVENT, 1'b0, 4'b0000, 1'b1, '{32'd0, 32'd1, 32'd1}},
    '{OP_EVENT, 1'b0, 4'b0001, 1'b0, '0},
    '{OP_EVENT, 1'b0, 4'b0010, 1'b0, '0},
    '{OP_EVENT, 1'b0, 4'b0011, 1'b0, '0},
    '{OP_EVENT, 1'b0, 4'b0000, 1'b0, '0}
  };

  dual_quadrature_odometer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_dual_quadrature_odometer failed");
      $finish;
    end
  end

  // Distance from the current counts: floor of the mean, scaled, truncated
  // toward zero and saturated
  function automatic logic [31:0] travelled_mm();
    longint          half_sum;
    longint unsigned circ, divisor, mag, quo, rem, total;
    half_sum = (longint'(signed'(enc_count[0])) + longint'(signed'(enc_count[1]))) >>> 1;
    circ = (64'(wheel_mm) * PI_NUM) / PI_DEN;
    divisor = 64'(steps_rev) * 64'(gear_red);
    if (divisor == 0 || circ == 0) return 32'd0;
    mag = (half_sum < 0) ? longint'(-half_sum) : longint'(half_sum);
    quo = mag / divisor;
    rem = mag % divisor;
    total = quo * circ + (rem * circ) / divisor;
    if (half_sum < 0) begin
      if (total >= 64'h8000_0000) return DIST_SAT_NEG;
      return 32'd0 - total[31:0];
    end
    if (total > 64'h7FFF_FFFF) return DIST_SAT_POS;
    return total[31:0];
  endfunction

  // Decode one request into the model state and return its result
  function automatic odo_result_t predict_request(logic op, logic sel, logic [3:0] pins);
    logic [1:0]  a_new;
    logic [1:0]  b_new;
    odo_result_t res;
    b_new = {pins[3], pins[1]};
    a_new = {pins[2] ^ pins[3], pins[0] ^ pins[1]};
    if (op == OP_CLEAR) begin
      enc_count[0] = '0;
      enc_count[1] = '0;
      last_a = a_new;
      last_b = b_new;
    end else begin
      if (a_new[sel] != last_b[sel]) enc_count[sel] = enc_count[sel] + 32'd1;
      if (b_new[sel] != last_a[sel]) enc_count[sel] = enc_count[sel] - 32'd1;
      last_a[sel] = a_new[sel];
      last_b[sel] = b_new[sel];
    end
    res.left = enc_count[0];
    res.right = enc_count[1];
    res.distance = travelled_mm();
    return res;
  endfunction

  // Offer one request after a random gap and record its expected result
  task automatic send_request(input logic op, input logic sel, input logic [3:0] pins,
                              input logic typed, input odo_result_t typed_res);
    int unsigned gap;
    odo_result_t res;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {sel, op};
    s_axis_tdata <= {4'b0000, pins};
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_request(op, sel, pins);
    if (typed) res = typed_res;
    pending_results.push_back(res);
    pin_a = {pins[2] ^ pins[3], pins[0] ^ pins[1]};
    pin_b = {pins[3], pins[1]};
  endtask

  // Let the block drain before touching the configuration
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [7:0] diam, input logic [7:0] steps,
                               input logic [7:0] gear);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_DIAMETER, CFG_STEPS, CFG_GEAR};
    val = '{diam, steps, gear};
    for (int k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    wheel_mm = diam;
    steps_rev = steps;
    gear_red = gear;
  endtask

  // Mostly clean quadrature steps with a bias, some noise and rare clears
  task automatic run_walk(input int unsigned n_items, input int unsigned fwd_pct);
    int unsigned kind;
    logic        sel;
    logic [1:0]  na;
    logic [1:0]  nb;
    for (int unsigned i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 99);
      sel = 1'($urandom_range(0, 1));
      if (kind < 3) begin
        send_request(OP_CLEAR, sel, 4'($urandom_range(0, 15)), 1'b0, '0);
      end else if (kind < 13) begin
        send_request(OP_EVENT, sel, 4'($urandom_range(0, 15)), 1'b0, '0);
      end else begin
        na = pin_a;
        nb = pin_b;
        if ($urandom_range(0, 99) < fwd_pct) begin
          if (na[sel] == nb[sel]) na[sel] = ~na[sel];
          else nb[sel] = ~nb[sel];
        end else begin
          if (na[sel] == nb[sel]) nb[sel] = ~nb[sel];
          else na[sel] = ~na[sel];
        end
        send_request(OP_EVENT, sel, {nb[1], na[1] ^ nb[1], nb[0], na[0] ^ nb[0]},
                     1'b0, '0);
      end
    end
  endtask

  // Stimulus
  initial begin : request_source
    logic [7:0]  fixed_cfg [6][3];
    int unsigned fixed_len [6];
    fixed_cfg = '{'{8'd255, 8'd1, 8'd1}, '{8'd1, 8'd255, 8'd255}, '{8'd0, 8'd12, 8'd75},
                  '{8'd39, 8'd0, 8'd75}, '{8'd39, 8'd12, 8'd0}, '{8'd255, 8'd255, 8'd255}};
    fixed_len = '{150, 100, 40, 30, 30, 80};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, reset configuration
    for (int r = 0; r < N_ROWS; r++) begin
      send_request(directed_rows[r].op, directed_rows[r].sel, directed_rows[r].pins,
                   directed_rows[r].typed, directed_rows[r].want);
    end

    // Extreme and degenerate settings
    for (int p = 0; p < 6; p++) begin
      settle();
      load_settings(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2]);
      calm = (p == 2);
      run_walk(fixed_len[p], $urandom_range(20, 95));
    end

    // Random settings
    for (int p = 0; p < 6; p++) begin
      settle();
      load_settings(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                    8'($urandom_range(1, 255)));
      calm = (p == 3);
      run_walk(110, $urandom_range(10, 95));
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("tb_dual_quadrature_odometer passed");
    end else begin
      $display("tb_dual_quadrature_odometer failed");
    end
    $finish;
  end

  // Result sink and checker
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    odo_result_t got;
    odo_result_t want;
    taken = 0;
    wait (rst_ni);
    forever begin
      if (taken == HOLD_AT) stall = LONG_HOLD;
      else stall = calm ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.left !== want.left) begin
          $display("%0t: left_count expected %0d, got %0d", $time,
                   signed'(want.left), signed'(got.left));
          fault_count++;
        end
        if (got.right !== want.right) begin
          $display("%0t: right_count expected %0d, got %0d", $time,
                   signed'(want.right), signed'(got.right));
          fault_count++;
        end
        if (got.distance !== want.distance) begin
          $display("%0t: distance_mm expected %0d, got %0d", $time,
                   signed'(want.distance), signed'(got.distance));
          fault_count++;
        end
      end
    end
  end

endmodule
